FILE: rtl/core/prq_pkg.sv
// Shared types and codes for the priority run queue dispatcher.
// No dependencies; priority_run_queue_dispatcher.sv and prq_cell.sv use this package.
package prq_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_YIELD  = 2'd1;
  localparam logic [1:0] OP_BLOCK  = 2'd2;

  typedef enum logic [1:0] {
    CH_HOLD,
    CH_INSERT,
    CH_POP
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
  } chain_cmd_t;

endpackage

FILE: rtl/core/prq_if.sv
// Valid/ready channel interfaces for the command beat and the result beat.
// Depends on nothing; the top level takes one port of each.
interface prq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] thread_id;
  logic [7:0] thread_priority;

  modport source (output valid, output opcode, output thread_id, output thread_priority,
                  input ready);
  modport sink   (input valid, input opcode, input thread_id, input thread_priority,
                  output ready);
endinterface

interface prq_out_if;
  logic       valid;
  logic       ready;
  logic       running_valid;
  logic [3:0] running_id;
  logic [7:0] running_level;
  logic [4:0] queued_count;
  logic       dropped;

  modport source (output valid, output running_valid, output running_id,
                  output running_level, output queued_count, output dropped,
                  input ready);
  modport sink   (input valid, input running_valid, input running_id,
                  input running_level, input queued_count, input dropped,
                  output ready);
endinterface

FILE: rtl/core/priority_run_queue_dispatcher.sv
// Top level of the priority run queue dispatcher: command sequencer, running
// thread registers and the chain of prq_cell slots. Depends on prq_pkg, prq_if.
//
// Usage:
//   The in_ch channel carries one command beat (opcode, thread_id,
//   thread_priority). Opcode insert queues a thread behind all threads of
//   equal or higher priority, yield re-queues the running thread and
//   dispatches the head (on a full queue, only if its priority is equal
//   or higher), block drops the running thread and dispatches. The out_ch
//   channel returns one result beat per command: the running thread after
//   the command, the queue fill and a drop flag for a refused insert.
//   Each command is latched on acceptance, then runs two chain steps (every
//   slot moves in parallel, so an insert or a pop costs the same regardless
//   of queue depth), then its result is registered for the result beat. A
//   new command is taken only after the previous one has produced its
//   result beat and the result side can take that beat.
//   A result beat waits in the output register while out_ch.ready is low;
//   the next command is accepted in the cycle that beat is taken.
//   Reset (rst_n low, synchronous) empties the queue and clears the running
//   thread; the slots themselves are not cleared.
module priority_run_queue_dispatcher #(
  parameter int QUEUE_DEPTH = 16,
  parameter int LEVEL_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  prq_in_if.sink     in_ch,
  prq_out_if.source  out_ch
);

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP1,
    S_STEP2,
    S_REPORT
  } state_t;

  state_t                state_r;
  logic [1:0]            cmd_op_r;
  logic [3:0]            cmd_id_r;
  logic [LEVEL_BITS-1:0] cmd_level_r;
  prq_pkg::chain_op_t    pend_r;
  logic                  drop_r;
  logic [FILL_W-1:0]     fill_r;
  logic                  cur_valid_r;
  logic [3:0]            cur_id_r;
  logic [LEVEL_BITS-1:0] cur_level_r;

  logic                  out_valid_r;
  logic                  out_run_valid_r;
  logic [3:0]            out_id_r;
  logic [7:0]            out_level_r;
  logic [4:0]            out_count_r;
  logic                  out_drop_r;

  prq_pkg::chain_cmd_t   chain_cmd;
  prq_pkg::chain_op_t    plan;
  logic                  save_cur;
  logic                  drop_now;
  logic [3:0]            ins_id;
  logic [LEVEL_BITS-1:0] ins_level;
  logic                  full;
  logic                  accept;

  logic [LEVEL_BITS+7:0] in_level_ext;
  logic [LEVEL_BITS+7:0] out_level_ext;
  logic [FILL_W+4:0]     fill_ext;

  logic [3:0]            cell_id    [QUEUE_DEPTH];
  logic [LEVEL_BITS-1:0] cell_level [QUEUE_DEPTH];
  logic                  cell_stay  [QUEUE_DEPTH];

  assign full          = fill_r == FILL_W'(QUEUE_DEPTH);
  assign in_ch.ready   = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept        = in_ch.valid && in_ch.ready;
  assign in_level_ext  = {{LEVEL_BITS{1'b0}}, in_ch.thread_priority};
  assign out_level_ext = {8'b0, cur_level_r};
  assign fill_ext      = {5'b0, fill_r};

  always_comb begin
    chain_cmd.op = prq_pkg::CH_HOLD;
    plan         = prq_pkg::CH_HOLD;
    save_cur     = 1'b0;
    drop_now     = 1'b0;
    ins_id       = cmd_id_r;
    ins_level    = cmd_level_r;
    if (state_r == S_STEP1) begin
      case (cmd_op_r)
        prq_pkg::OP_INSERT: begin
          if (full) drop_now = 1'b1;
          else chain_cmd.op = prq_pkg::CH_INSERT;
        end
        prq_pkg::OP_YIELD: begin
          if (!cur_valid_r) begin
            chain_cmd.op = prq_pkg::CH_POP;
          end else if (full) begin
            if (cell_level[0] >= cur_level_r) begin
              chain_cmd.op = prq_pkg::CH_POP;
              plan         = prq_pkg::CH_INSERT;
              save_cur     = 1'b1;
            end
          end else begin
            chain_cmd.op = prq_pkg::CH_INSERT;
            ins_id       = cur_id_r;
            ins_level    = cur_level_r;
            plan         = prq_pkg::CH_POP;
          end
        end
        prq_pkg::OP_BLOCK: chain_cmd.op = prq_pkg::CH_POP;
        default: ;
      endcase
    end else if (state_r == S_STEP2) begin
      chain_cmd.op = pend_r;
    end
  end

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    localparam int L = (k == 0) ? 0 : k - 1;
    localparam int R = (k == QUEUE_DEPTH - 1) ? k : k + 1;
    prq_cell #(.LEVEL_BITS(LEVEL_BITS)) u_cell (
      .clk         (clk),
      .cmd         (chain_cmd),
      .new_id      (ins_id),
      .new_level   (ins_level),
      .occupied    (FILL_W'(k) < fill_r),
      .left_stay   ((k == 0) ? 1'b1 : cell_stay[L]),
      .left_id     (cell_id[L]),
      .left_level  (cell_level[L]),
      .right_id    (cell_id[R]),
      .right_level (cell_level[R]),
      .stay        (cell_stay[k]),
      .id          (cell_id[k]),
      .level       (cell_level[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cur_valid_r <= 1'b0;
      cur_id_r    <= '0;
      cur_level_r <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= prq_pkg::CH_HOLD;
      drop_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_op_r    <= in_ch.opcode;
            cmd_id_r    <= in_ch.thread_id;
            cmd_level_r <= in_level_ext[LEVEL_BITS-1:0];
            state_r     <= S_STEP1;
          end
        end
        S_STEP1: begin
          pend_r  <= plan;
          drop_r  <= drop_now;
          state_r <= S_STEP2;
          if (save_cur) begin
            cmd_id_r    <= cur_id_r;
            cmd_level_r <= cur_level_r;
          end
        end
        S_STEP2: state_r <= S_REPORT;
        S_REPORT: begin
          out_valid_r     <= 1'b1;
          out_run_valid_r <= cur_valid_r;
          out_id_r        <= cur_id_r;
          out_level_r     <= out_level_ext[7:0];
          out_count_r     <= fill_ext[4:0];
          out_drop_r      <= drop_r;
          state_r         <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (chain_cmd.op == prq_pkg::CH_INSERT) begin
        fill_r <= fill_r + FILL_W'(1);
      end else if (chain_cmd.op == prq_pkg::CH_POP) begin
        if (fill_r != '0) begin
          fill_r      <= fill_r - FILL_W'(1);
          cur_valid_r <= 1'b1;
          cur_id_r    <= cell_id[0];
          cur_level_r <= cell_level[0];
        end else begin
          cur_valid_r <= 1'b0;
          cur_id_r    <= '0;
          cur_level_r <= '0;
        end
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.running_valid = out_run_valid_r;
  assign out_ch.running_id    = out_id_r;
  assign out_ch.running_level = out_level_r;
  assign out_ch.queued_count  = out_count_r;
  assign out_ch.dropped       = out_drop_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(QUEUE_DEPTH))
    else $error("queue fill exceeds depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == $past(fill_r)) || (fill_r == $past(fill_r) + FILL_W'(1)) ||
    (fill_r == $past(fill_r) - FILL_W'(1)))
    else $error("queue fill moved by more than one");

  a_idle_current: assert property (@(posedge clk) disable iff (!rst_n)
    !cur_valid_r |-> (cur_id_r == '0) && (cur_level_r == '0))
    else $error("stale running thread while nothing runs");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drop_r) |-> full)
    else $error("drop reported while queue has room");

  a_accept_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_STEP1))
    else $error("accepted command did not start");

endmodule

FILE: rtl/core/prq_cell.sv
// One slot of the sorted run queue: holds an id and a level and shifts
// toward its neighbors on insert or pop. Depends on prq_pkg.
module prq_cell #(
  parameter int LEVEL_BITS = 8
) (
  input  logic                     clk,
  input  prq_pkg::chain_cmd_t      cmd,
  input  logic [3:0]               new_id,
  input  logic [LEVEL_BITS-1:0]    new_level,
  input  logic                     occupied,
  input  logic                     left_stay,
  input  logic [3:0]               left_id,
  input  logic [LEVEL_BITS-1:0]    left_level,
  input  logic [3:0]               right_id,
  input  logic [LEVEL_BITS-1:0]    right_level,
  output logic                     stay,
  output logic [3:0]               id,
  output logic [LEVEL_BITS-1:0]    level
);

  logic [3:0]            id_r, id_nxt;
  logic [LEVEL_BITS-1:0] level_r, level_nxt;

  assign stay  = occupied && (level_r >= new_level);
  assign id    = id_r;
  assign level = level_r;

  always_comb begin
    id_nxt    = id_r;
    level_nxt = level_r;
    case (cmd.op)
      prq_pkg::CH_INSERT: begin
        if (!stay) begin
          if (left_stay) begin
            id_nxt    = new_id;
            level_nxt = new_level;
          end else begin
            id_nxt    = left_id;
            level_nxt = left_level;
          end
        end
      end
      prq_pkg::CH_POP: begin
        id_nxt    = right_id;
        level_nxt = right_level;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    level_r <= level_nxt;
  end

endmodule
